// File: rtl/core/h264_rtp_keyframe_detector_unit_assert.svh
// Assertion macros for the H.264 RTP keyframe detector.
// Included by the top level; the macros are empty when SYNTHESIS is defined.
`ifndef H264_RTP_KEYFRAME_DETECTOR_UNIT_ASSERT_SVH
`define H264_RTP_KEYFRAME_DETECTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge outside reset.
`define KFD_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// Checks that a condition in one cycle leads to another in the next cycle.
`define KFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KFD_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define KFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/h264kf_pkg.sv
// Package for the H.264 RTP keyframe detector: parse phases and NAL type codes.
// No dependencies.
`default_nettype none
package h264kf_pkg;

    typedef enum logic [2:0] {
        PH_FIRST     = 3'd0,
        PH_FU_SECOND = 3'd1,
        PH_DRAIN     = 3'd2,
        PH_SIZE_HI   = 3'd3,
        PH_SIZE_LO   = 3'd4,
        PH_NAL_HEAD  = 3'd5,
        PH_NAL_BODY  = 3'd6
    } t_phase;

    localparam logic [7:0] TYPE_MASK  = 8'h1F;
    localparam logic [4:0] TYPE_FUA   = 5'd28;
    localparam logic [4:0] TYPE_STAPA = 5'd24;
    localparam logic [4:0] TYPE_SPS   = 5'd7;
    localparam logic [4:0] TYPE_IDR   = 5'd5;

    localparam int unsigned SIZE_W = 16;
    localparam logic [1:0] SEEN_MAX = 2'd3;

endpackage
`default_nettype wire

// File: rtl/core/h264_rtp_keyframe_detector_unit.sv
// Top level of the H.264 RTP keyframe detector: byte parser and result register.
// Depends on h264kf_pkg and h264_rtp_keyframe_detector_unit_assert.svh.
//
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] payload_byte, tlast last_byte
// m_axis    out        tdata[0] parse_ok, tdata[1] keyframe, tdata[7:2] zero
//
// Each accepted byte updates the parse state directly; a final byte loads
// the result register, whose result appears the cycle after.
// The block takes a byte in every cycle unless a result waits in the result
// register and m_axis_tready is low. Reset is synchronous, active low, and
// returns the parser to the start of a payload with no result pending.
`default_nettype none
`include "h264_rtp_keyframe_detector_unit_assert.svh"
module h264_rtp_keyframe_detector_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] payload_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [0] parse_ok, [1] keyframe, rest zero
);
    import h264kf_pkg::*;

    t_phase              r_phase, n_phase, w_phase_step;
    logic [SIZE_W-1:0]   r_bytes_left, n_bytes_left, w_left_dec;
    logic [7:0]          r_size_high, n_size_high;
    logic [1:0]          r_seen_count, n_seen_count;
    logic                r_key_seen, n_key_seen, w_key_step;
    logic                r_error_seen, n_error_seen, w_err_step;
    logic                r_is_stap, n_is_stap, w_stap_step;
    logic                r_out_valid, n_out_valid;
    logic                r_parse_ok, n_parse_ok;
    logic                r_keyframe, n_keyframe;
    logic                w_accept, w_last, w_err_final, w_size_zero;
    logic [4:0]          w_type;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_last        = w_accept && s_axis_tlast;
    assign w_type        = 5'(s_axis_tdata & TYPE_MASK);
    assign w_left_dec    = r_bytes_left - SIZE_W'(1);
    assign w_size_zero   = ({r_size_high, s_axis_tdata} == '0);

    // Phase that the current byte leads to.
    always_comb begin
        w_phase_step = r_phase;
        case (r_phase)
            PH_FIRST: begin
                if (w_type == TYPE_FUA) begin
                    w_phase_step = PH_FU_SECOND;
                end else if (w_type == TYPE_STAPA) begin
                    w_phase_step = PH_SIZE_HI;
                end else begin
                    w_phase_step = PH_DRAIN;
                end
            end
            PH_FU_SECOND: w_phase_step = PH_DRAIN;
            PH_SIZE_HI:   w_phase_step = PH_SIZE_LO;
            PH_SIZE_LO:   w_phase_step = w_size_zero ? PH_DRAIN : PH_NAL_HEAD;
            PH_NAL_HEAD:  w_phase_step = (w_left_dec == '0) ? PH_SIZE_HI : PH_NAL_BODY;
            PH_NAL_BODY:  w_phase_step = (w_left_dec == '0) ? PH_SIZE_HI : PH_NAL_BODY;
            default:      w_phase_step = r_phase;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            n_phase = w_last ? PH_FIRST : w_phase_step;
        end
    end

    // Flags, counters and the result that the current byte produces.
    always_comb begin
        w_key_step   = r_key_seen;
        w_err_step   = r_error_seen;
        w_stap_step  = r_is_stap;
        n_bytes_left = r_bytes_left;
        n_size_high  = r_size_high;
        case (r_phase)
            PH_FIRST: begin
                if (w_type == TYPE_STAPA) begin
                    w_stap_step = 1'b1;
                end else if (w_type != TYPE_FUA &&
                             (w_type == TYPE_IDR || w_type == TYPE_SPS)) begin
                    w_key_step = 1'b1;
                end
            end
            PH_FU_SECOND: begin
                if (w_type == TYPE_IDR) begin
                    w_key_step = 1'b1;
                end
            end
            PH_SIZE_HI: n_size_high = s_axis_tdata;
            PH_SIZE_LO: begin
                if (w_size_zero) begin
                    w_err_step = 1'b1;
                end else begin
                    n_bytes_left = {r_size_high, s_axis_tdata};
                end
            end
            PH_NAL_HEAD: begin
                if (w_type == TYPE_IDR || w_type == TYPE_SPS) begin
                    w_key_step = 1'b1;
                end
                n_bytes_left = w_left_dec;
            end
            PH_NAL_BODY: n_bytes_left = w_left_dec;
            default: ;
        endcase

        // A STAP-A needs at least four bytes and must end on a NAL boundary.
        w_err_final = w_err_step || (w_phase_step == PH_FU_SECOND);
        if (w_stap_step) begin
            if (r_seen_count < SEEN_MAX) begin
                w_err_final = 1'b1;
            end
            if (w_phase_step inside {PH_SIZE_LO, PH_NAL_HEAD, PH_NAL_BODY}) begin
                w_err_final = 1'b1;
            end
        end

        n_key_seen   = r_key_seen;
        n_error_seen = r_error_seen;
        n_is_stap    = r_is_stap;
        n_seen_count = r_seen_count;
        if (w_accept) begin
            if (w_last) begin
                n_key_seen   = 1'b0;
                n_error_seen = 1'b0;
                n_is_stap    = 1'b0;
                n_seen_count = '0;
                n_bytes_left = '0;
                n_size_high  = '0;
            end else begin
                n_key_seen   = w_key_step;
                n_error_seen = w_err_step;
                n_is_stap    = w_stap_step;
                n_seen_count = (r_seen_count == SEEN_MAX) ? SEEN_MAX
                                                          : r_seen_count + 2'd1;
            end
        end else begin
            n_bytes_left = r_bytes_left;
            n_size_high  = r_size_high;
        end

        n_out_valid = r_out_valid && !m_axis_tready;
        n_parse_ok  = r_parse_ok;
        n_keyframe  = r_keyframe;
        if (w_last) begin
            n_out_valid = 1'b1;
            n_parse_ok  = !w_err_final;
            n_keyframe  = w_key_step && !w_err_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FIRST;
            r_bytes_left <= '0;
            r_size_high  <= '0;
            r_seen_count <= '0;
            r_key_seen   <= 1'b0;
            r_error_seen <= 1'b0;
            r_is_stap    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_size_high  <= n_size_high;
            r_seen_count <= n_seen_count;
            r_key_seen   <= n_key_seen;
            r_error_seen <= n_error_seen;
            r_is_stap    <= n_is_stap;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_parse_ok <= n_parse_ok;
        r_keyframe <= n_keyframe;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_keyframe, r_parse_ok};

    `KFD_ASSERT_ALWAYS(a_key_needs_ok, i_clk, i_rst_n, !r_out_valid || r_parse_ok || !r_keyframe)
    `KFD_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, w_last, r_out_valid && r_phase == PH_FIRST)
    `KFD_ASSERT_ALWAYS(a_midpayload_counted, i_clk, i_rst_n, r_phase == PH_FIRST || r_seen_count != 2'd0)
    `KFD_ASSERT_ALWAYS(a_error_drains, i_clk, i_rst_n, !r_error_seen || r_phase == PH_DRAIN)

endmodule
`default_nettype wire
